// ----- rtl/coalescing_mutation_table_defines.svh -----
// Assertion macros for the checker file of the mutation table.
`ifndef COALESCING_MUTATION_TABLE_DEFINES_SVH
`define COALESCING_MUTATION_TABLE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent, outside reset.
`define CMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent, outside reset.
`define CMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

// Checked also while reset is applied.
`define CMT_ASSERT_RST(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/cmt_pkg.sv -----
package cmt_pkg;

    // Table geometry.
    localparam int SLOTS    = 8;
    localparam int KEY_BITS = 32;
    localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Fixed widths of the port fields.
    localparam int REQ_W     = 2;
    localparam int PORT_KEY_W = 32;
    localparam int STATE_W   = 2;
    localparam int SEQ_W     = 32;
    localparam int STATUS_W  = 2;
    localparam int SLOT_W    = 3;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_STATE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_SNAP   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_ACK    = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // State code stored for a delete.
    localparam logic [STATE_W-1:0] STATE_NONE = 2'd0;

    typedef logic [IDX_W-1:0]    t_idx;
    typedef logic [SLOTS-1:0]    t_mask;
    typedef logic [KEY_BITS-1:0] t_key;

    // One slot of the table memory.
    typedef struct packed {
        t_key               key;
        logic [STATE_W-1:0] state;
        logic               deleted;
        logic [SEQ_W-1:0]   seq;
    } t_entry;

    // One result beat.
    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_W-1:0]     slot;
        logic                  valid;
        logic [PORT_KEY_W-1:0] key;
        logic [STATE_W-1:0]    state;
        logic                  deleted;
        logic [SEQ_W-1:0]      seq;
        logic                  any_pending;
        logic                  last;
    } t_result;

    // Index of the lowest set bit; zero when no bit is set.
    function automatic t_idx first_set(input t_mask m);
        t_idx r;
        r = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (m[i]) begin
                r = t_idx'(i);
            end
        end
        return r;
    endfunction

endpackage

// ----- rtl/coalescing_mutation_table.sv -----
// Channel | Handshake           | Beat
// --------+---------------------+------------------------------------------------
// request | i_valid / o_stall   | i_req_type, i_task_key, i_new_state, i_ack_seq
// result  | o_valid / i_stall   | o_op_status .. o_last, one or more per request
//
// A request walks the pending slots one by one: each visited slot costs a read of
// the slot memory in S_NEXT and a check of the registered read data in S_CHECK.
// An enqueue stops early on a key hit.
// Reset clears the pending bits and the sequence counter at once; slot memory is
// not cleared. A waiting result does not stop a new request from being taken;
// a stalled result only holds the walk at the point where it must emit.
module coalescing_mutation_table import cmt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [PORT_KEY_W-1:0] i_task_key,
    input  logic [STATE_W-1:0]    i_new_state,
    input  logic [SEQ_W-1:0]      i_ack_seq,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [STATUS_W-1:0]   o_op_status,
    output logic [SLOT_W-1:0]     o_slot,
    output logic                  o_entry_valid,
    output logic [PORT_KEY_W-1:0] o_entry_key,
    output logic [STATE_W-1:0]    o_entry_state,
    output logic                  o_entry_deleted,
    output logic [SEQ_W-1:0]      o_entry_seq,
    output logic                  o_any_pending,
    output logic                  o_last
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_NEXT   = 2'd1;
    localparam logic [1:0] S_CHECK  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    // Control state.
    logic [1:0]       r_state, n_state;
    t_mask            r_pending, n_pending;
    logic [SEQ_W-1:0] r_seq, n_seq;
    logic             r_out_vld, n_out_vld;

    // Request and walk registers.
    logic [REQ_W-1:0]   r_req, n_req;
    t_key               r_key, n_key;
    logic [STATE_W-1:0] r_nst, n_nst;
    logic [SEQ_W-1:0]   r_aseq, n_aseq;
    t_mask              r_mask, n_mask;
    t_idx               r_idx, n_idx;
    t_idx               r_pick, n_pick;
    logic               r_hit, n_hit;
    logic               r_emitted, n_emitted;
    t_result            r_out, n_out;

    // Slot memory and its ports.
    t_entry r_mem [SLOTS];
    t_entry r_rd;
    logic   mem_re;
    t_idx   mem_ra;
    logic   mem_we;
    t_idx   mem_wa;
    t_entry mem_wd;

    logic    out_free;
    logic    is_enq;
    t_key    in_key;
    t_idx    scan_idx;
    t_idx    free_idx;
    logic    any_free;
    t_idx    put_idx;
    t_result empty_res;

    assign out_free = !r_out_vld || !i_stall;
    assign is_enq   = (r_req == REQ_STATE) || (r_req == REQ_DELETE);
    assign in_key   = KEY_BITS'(i_task_key);
    assign scan_idx = first_set(r_mask);
    assign free_idx = first_set(~r_pending);
    assign any_free = !(&r_pending);
    assign put_idx  = r_hit ? r_pick : (any_free ? free_idx : '0);

    // Result with no entry, marked last and carrying the pending flag; status is set per use.
    always_comb begin
        empty_res             = '0;
        empty_res.last        = 1'b1;
        empty_res.any_pending = |r_pending;
    end

    // Walk sequencer: one memory read per pending slot visited, then the result or the update.
    always_comb begin
        n_state   = r_state;
        n_pending = r_pending;
        n_seq     = r_seq;
        n_req     = r_req;
        n_key     = r_key;
        n_nst     = r_nst;
        n_aseq    = r_aseq;
        n_mask    = r_mask;
        n_idx     = r_idx;
        n_pick    = r_pick;
        n_hit     = r_hit;
        n_emitted = r_emitted;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_stall;
        mem_re    = 1'b0;
        mem_ra    = scan_idx;
        mem_we    = 1'b0;
        mem_wa    = put_idx;
        mem_wd    = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_req     = i_req_type;
                    n_key     = in_key;
                    n_nst     = i_new_state;
                    n_aseq    = i_ack_seq;
                    n_mask    = r_pending;
                    n_hit     = 1'b0;
                    n_emitted = 1'b0;
                    if ((i_req_type == REQ_STATE || i_req_type == REQ_DELETE)
                            && in_key == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_NEXT;
                    end
                end
            end

            S_NEXT: begin
                if (|r_mask) begin
                    mem_re           = 1'b1;
                    n_mask[scan_idx] = 1'b0;
                    n_idx            = scan_idx;
                    n_state          = S_CHECK;
                end else begin
                    n_state = S_FINISH;
                end
            end

            S_CHECK: begin
                case (r_req)
                    REQ_SNAP: begin
                        if (out_free) begin
                            n_out.status      = ST_DONE;
                            n_out.slot        = SLOT_W'(r_idx);
                            n_out.valid       = 1'b1;
                            n_out.key         = PORT_KEY_W'(r_rd.key);
                            n_out.state       = r_rd.state;
                            n_out.deleted     = r_rd.deleted;
                            n_out.seq         = r_rd.seq;
                            n_out.any_pending = |r_pending;
                            n_out.last        = (r_mask == '0);
                            n_out_vld         = 1'b1;
                            n_emitted         = 1'b1;
                            n_state           = S_NEXT;
                        end
                    end
                    REQ_ACK: begin
                        if (r_rd.seq == r_aseq && r_rd.key == r_key) begin
                            n_pending[r_idx] = 1'b0;
                        end
                        n_state = S_NEXT;
                    end
                    default: begin
                        if (r_rd.key == r_key) begin
                            n_hit   = 1'b1;
                            n_pick  = r_idx;
                            n_state = S_FINISH;
                        end else begin
                            n_state = S_NEXT;
                        end
                    end
                endcase
            end

            S_FINISH: begin
                case (r_req)
                    REQ_SNAP: begin
                        if (r_emitted) begin
                            n_state = S_IDLE;
                        end else if (out_free) begin
                            n_out     = empty_res;
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    REQ_ACK: begin
                        if (out_free) begin
                            n_out     = empty_res;
                            n_out_vld = 1'b1;
                            n_state   = S_IDLE;
                        end
                    end
                    default: begin
                        if (out_free && r_key == '0) begin
                            n_out        = empty_res;
                            n_out.status = ST_IGNORED;
                            n_out_vld    = 1'b1;
                            n_state      = S_IDLE;
                        end else if (out_free) begin
                            // Coalesce into the hit, else the first free slot, else slot 0.
                            n_seq          = r_seq + 1'b1;
                            mem_we         = 1'b1;
                            mem_wd.key     = r_key;
                            mem_wd.state   = (r_req == REQ_DELETE) ? STATE_NONE : r_nst;
                            mem_wd.deleted = (r_req == REQ_DELETE);
                            mem_wd.seq     = n_seq;
                            n_pending[put_idx] = 1'b1;
                            n_out.status      = (r_hit || any_free) ? ST_DONE : ST_FULL;
                            n_out.slot        = SLOT_W'(put_idx);
                            n_out.valid       = 1'b1;
                            n_out.key         = PORT_KEY_W'(mem_wd.key);
                            n_out.state       = mem_wd.state;
                            n_out.deleted     = mem_wd.deleted;
                            n_out.seq         = mem_wd.seq;
                            n_out.any_pending = 1'b1;
                            n_out.last        = 1'b1;
                            n_out_vld         = 1'b1;
                            n_state           = S_IDLE;
                        end
                    end
                endcase
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pending <= '0;
            r_seq     <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_pending <= n_pending;
            r_seq     <= n_seq;
            r_out_vld <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_req     <= n_req;
        r_key     <= n_key;
        r_nst     <= n_nst;
        r_aseq    <= n_aseq;
        r_mask    <= n_mask;
        r_idx     <= n_idx;
        r_pick    <= n_pick;
        r_hit     <= n_hit;
        r_emitted <= n_emitted;
        r_out     <= n_out;
    end

    // Slot memory: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (mem_re) begin
            r_rd <= r_mem[mem_ra];
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_valid         = r_out_vld;
    assign o_op_status     = r_out.status;
    assign o_slot          = r_out.slot;
    assign o_entry_valid   = r_out.valid;
    assign o_entry_key     = r_out.key;
    assign o_entry_state   = r_out.state;
    assign o_entry_deleted = r_out.deleted;
    assign o_entry_seq     = r_out.seq;
    assign o_any_pending   = r_out.any_pending;
    assign o_last          = r_out.last;

endmodule

// ----- rtl/cmt_checker.sv -----
`include "coalescing_mutation_table_defines.svh"

module cmt_checker import cmt_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [STATUS_W-1:0]   o_op_status,
    input logic                  o_entry_valid,
    input logic [SEQ_W-1:0]      o_entry_seq,
    input logic                  o_any_pending,
    input logic                  o_last
);

    // No result beat is offered right after reset.
    `CMT_ASSERT_RST(a_no_beat_after_reset, !i_rst_n, !o_valid, "result valid after reset")

    // A request beat is followed by the table walking, so no second beat is taken.
    `CMT_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall, "request taken back to back")

    // An ignored enqueue carries no entry and closes its request.
    `CMT_ASSERT_NOW(a_ignored_shape, o_valid && o_op_status == ST_IGNORED,
        !o_entry_valid && o_last, "ignored result carries an entry")

    // A result that carries an entry implies some slot is still pending.
    `CMT_ASSERT_NOW(a_entry_pending, o_valid && o_entry_valid, o_any_pending,
        "entry reported with no slot pending")

    // A stalled result beat holds.
    `CMT_ASSERT_NEXT(a_stall_holds, o_valid && i_stall,
        o_valid && $stable(o_entry_seq) && $stable(o_last), "stalled result changed")

endmodule

bind coalescing_mutation_table cmt_checker u_cmt_checker (.*);

// ----- tb/coalescing_mutation_table_checker.sv -----
// Watches both channels of the mutation table, keeps its own copy of the slot
// table and sequence counter, and compares every result beat with the oldest
// predicted one.
module coalescing_mutation_table_checker import cmt_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_stall,
    input  logic [REQ_W-1:0]      i_req_type,
    input  logic [PORT_KEY_W-1:0] i_task_key,
    input  logic [STATE_W-1:0]    i_new_state,
    input  logic [SEQ_W-1:0]      i_ack_seq,
    input  logic                  i_res_valid,
    input  logic                  i_res_stall,
    input  logic [STATUS_W-1:0]   i_op_status,
    input  logic [SLOT_W-1:0]     i_slot,
    input  logic                  i_entry_valid,
    input  logic [PORT_KEY_W-1:0] i_entry_key,
    input  logic [STATE_W-1:0]    i_entry_state,
    input  logic                  i_entry_deleted,
    input  logic [SEQ_W-1:0]      i_entry_seq,
    input  logic                  i_any_pending,
    input  logic                  i_last,
    output int                    o_fail_count,
    output int                    o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    // A snapshot never emits more beats than this.
    localparam int MAX_BEATS = 8;

    logic             slot_busy  [SLOTS];
    t_entry           slot_entry [SLOTS];
    logic [SEQ_W-1:0] seq_counter;
    t_result          expected_beats [$];
    t_result          seen_beat;
    int               fails = 0;

    // The field order matches the packed result struct.
    assign seen_beat = {i_op_status, i_slot, i_entry_valid, i_entry_key, i_entry_state,
                        i_entry_deleted, i_entry_seq, i_any_pending, i_last};

    // Builds one result beat from the mirrored table as it stands now.
    function automatic t_result table_beat(input logic [STATUS_W-1:0] status, input int idx,
                                           input logic carries, input logic is_last);
        t_result b;
        logic    busy;
        busy = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            busy = busy | slot_busy[i];
        end
        b = '0;
        b.status      = status;
        b.any_pending = busy;
        b.last        = is_last;
        if (carries) begin
            b.slot    = SLOT_W'(idx);
            b.valid   = 1'b1;
            b.key     = PORT_KEY_W'(slot_entry[idx].key);
            b.state   = slot_entry[idx].state;
            b.deleted = slot_entry[idx].deleted;
            b.seq     = slot_entry[idx].seq;
        end
        return b;
    endfunction

    // Applies one accepted request to the mirrored table and queues its beats.
    task automatic predict_request(input logic [REQ_W-1:0] req, input logic [PORT_KEY_W-1:0] key,
                                   input logic [STATE_W-1:0] st, input logic [SEQ_W-1:0] aseq);
        t_key                key_m;
        int                  pick;
        int                  count;
        int                  emitted;
        logic [STATUS_W-1:0] status;
        key_m = t_key'(key);
        case (req)
            REQ_STATE, REQ_DELETE: begin
                if (key_m == '0) begin
                    expected_beats.push_back(table_beat(ST_IGNORED, 0, 1'b0, 1'b1));
                end else begin
                    // A pending slot with the same key wins over the lowest free slot.
                    pick = -1;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_busy[i] && slot_entry[i].key == key_m) begin
                            pick = i;
                            break;
                        end
                        if (pick < 0 && !slot_busy[i]) begin
                            pick = i;
                        end
                    end
                    status = ST_DONE;
                    if (pick < 0) begin
                        pick   = 0;
                        status = ST_FULL;
                    end
                    seq_counter = seq_counter + 1'b1;
                    slot_entry[pick].key     = key_m;
                    slot_entry[pick].state   = (req == REQ_DELETE) ? STATE_NONE : st;
                    slot_entry[pick].deleted = (req == REQ_DELETE);
                    slot_entry[pick].seq     = seq_counter;
                    slot_busy[pick]          = 1'b1;
                    expected_beats.push_back(table_beat(status, pick, 1'b1, 1'b1));
                end
            end
            REQ_SNAP: begin
                count = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i] && count < MAX_BEATS) begin
                        count++;
                    end
                end
                if (count == 0) begin
                    expected_beats.push_back(table_beat(ST_DONE, 0, 1'b0, 1'b1));
                end else begin
                    emitted = 0;
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_busy[i] && emitted < count) begin
                            expected_beats.push_back(
                                table_beat(ST_DONE, i, 1'b1, emitted == count - 1));
                            emitted++;
                        end
                    end
                end
            end
            default: begin
                // Acknowledge: clear every pending slot whose key and sequence both match.
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_busy[i] && slot_entry[i].seq == aseq && slot_entry[i].key == key_m) begin
                        slot_busy[i] = 1'b0;
                    end
                end
                expected_beats.push_back(table_beat(ST_DONE, 0, 1'b0, 1'b1));
            end
        endcase
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fails++;
        end
    endtask

    task automatic check_beat(input t_result got);
        t_result want;
        if (expected_beats.size() == 0) begin
            $error("result beat arrived with no prediction waiting");
            fails++;
        end else begin
            want = expected_beats.pop_front();
            check_field("op_status", 64'(want.status), 64'(got.status));
            check_field("slot", 64'(want.slot), 64'(got.slot));
            check_field("entry_valid", 64'(want.valid), 64'(got.valid));
            check_field("entry_key", 64'(want.key), 64'(got.key));
            check_field("entry_state", 64'(want.state), 64'(got.state));
            check_field("entry_deleted", 64'(want.deleted), 64'(got.deleted));
            check_field("entry_seq", 64'(want.seq), 64'(got.seq));
            check_field("any_pending", 64'(want.any_pending), 64'(got.any_pending));
            check_field("last", 64'(want.last), 64'(got.last));
        end
    endtask

    // Results are checked before the request of the same edge is predicted, so an
    // empty queue never takes a beat that belongs to a later request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_busy[i]  = 1'b0;
                slot_entry[i] = '0;
            end
            seq_counter = '0;
            expected_beats.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                check_beat(seen_beat);
            end
            if (i_req_valid && !i_req_stall) begin
                predict_request(i_req_type, i_task_key, i_new_state, i_ack_seq);
            end
        end
        o_fail_count  <= fails;
        o_outstanding <= expected_beats.size();
    end

endmodule

// ----- tb/coalescing_mutation_table_tb.sv -----
// Stimulus and verdict for the mutation table; the checker does the comparing.
module coalescing_mutation_table_tb import cmt_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES  = 6;
    localparam int RANDOM_ITEMS  = 500;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PCT      = 7;
    localparam int POOL          = 12;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_stall;
    logic [REQ_W-1:0]      i_req_type;
    logic [PORT_KEY_W-1:0] i_task_key;
    logic [STATE_W-1:0]    i_new_state;
    logic [SEQ_W-1:0]      i_ack_seq;
    logic                  o_valid;
    logic                  i_stall;
    logic [STATUS_W-1:0]   o_op_status;
    logic [SLOT_W-1:0]     o_slot;
    logic                  o_entry_valid;
    logic [PORT_KEY_W-1:0] o_entry_key;
    logic [STATE_W-1:0]    o_entry_state;
    logic                  o_entry_deleted;
    logic [SEQ_W-1:0]      o_entry_seq;
    logic                  o_any_pending;
    logic                  o_last;

    int   fail_count;
    int   outstanding;
    int   cycle_count = 0;
    logic calm        = 1'b0;
    logic long_hold   = 1'b0;

    // Keys in use, with the sequence number of their latest enqueue, so that most
    // acknowledges can hit a real pending entry.
    logic [PORT_KEY_W-1:0] pool_key  [POOL];
    logic [SEQ_W-1:0]      pool_seq  [POOL];
    logic                  pool_seen [POOL];
    logic [SEQ_W-1:0]      enq_count = '0;

    coalescing_mutation_table u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_req_type      (i_req_type),
        .i_task_key      (i_task_key),
        .i_new_state     (i_new_state),
        .i_ack_seq       (i_ack_seq),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_op_status     (o_op_status),
        .o_slot          (o_slot),
        .o_entry_valid   (o_entry_valid),
        .o_entry_key     (o_entry_key),
        .o_entry_state   (o_entry_state),
        .o_entry_deleted (o_entry_deleted),
        .o_entry_seq     (o_entry_seq),
        .o_any_pending   (o_any_pending),
        .o_last          (o_last)
    );

    coalescing_mutation_table_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_valid     (i_valid),
        .i_req_stall     (o_stall),
        .i_req_type      (i_req_type),
        .i_task_key      (i_task_key),
        .i_new_state     (i_new_state),
        .i_ack_seq       (i_ack_seq),
        .i_res_valid     (o_valid),
        .i_res_stall     (i_stall),
        .i_op_status     (o_op_status),
        .i_slot          (o_slot),
        .i_entry_valid   (o_entry_valid),
        .i_entry_key     (o_entry_key),
        .i_entry_state   (o_entry_state),
        .i_entry_deleted (o_entry_deleted),
        .i_entry_seq     (o_entry_seq),
        .i_any_pending   (o_any_pending),
        .i_last          (o_last),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    // 8 ns clock.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Hard stop in case the block hangs.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stalls, none during the calm stretch, and one long hold.
    initial begin
        int   hold_left;
        logic held;
        hold_left = 0;
        held      = 1'b0;
        i_stall   = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold && !held) begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // Drives one request beat and returns at the edge that accepts it.
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [PORT_KEY_W-1:0] key,
                            input logic [STATE_W-1:0] st, input logic [SEQ_W-1:0] seq);
        i_valid     <= 1'b1;
        i_req_type  <= req;
        i_task_key  <= key;
        i_new_state <= st;
        i_ack_seq   <= seq;
        do @(posedge i_clk); while (o_stall);
        // Track the sequence number the block hands out for a real enqueue.
        if (req <= REQ_DELETE && key != '0) begin
            enq_count = enq_count + 1'b1;
            for (int j = 0; j < POOL; j++) begin
                if (pool_key[j] == key) begin
                    pool_seq[j]  = enq_count;
                    pool_seen[j] = 1'b1;
                end
            end
        end
    endtask

    // Sender gap of random length.
    task automatic rest_sender();
        i_valid <= 1'b0;
        do @(posedge i_clk); while ($urandom_range(0, 99) < 50);
    endtask

    // Sender pause until every predicted beat has been received.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    task automatic refresh_pool();
        for (int j = 0; j < POOL; j++) begin
            pool_key[j]  = $urandom;
            if (pool_key[j] == '0) begin
                pool_key[j] = 'd1;
            end
            pool_seen[j] = 1'b0;
        end
    endtask

    // Mostly keys from the pool so that enqueues coalesce and the table fills.
    function automatic logic [PORT_KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) begin
            return '0;
        end else if (r < 15) begin
            return $urandom;
        end
        return pool_key[$urandom_range(0, POOL - 1)];
    endfunction

    initial begin
        int                    r;
        int                    j;
        logic [PORT_KEY_W-1:0] key;
        logic [SEQ_W-1:0]      seq;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req_type  = REQ_SNAP;
        i_task_key  = '0;
        i_new_state = '0;
        i_ack_seq   = '0;
        for (int k = 0; k < POOL; k++) begin
            pool_key[k]  = PORT_KEY_W'(k);
            pool_seq[k]  = '0;
            pool_seen[k] = 1'b0;
        end
        pool_key[0]  = '1;
        pool_key[10] = 32'h8000_0000;
        pool_key[11] = 32'h5555_AAAA;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, empty keys, coalescing, a full table, snapshots and
        // acknowledges that hit and miss.
        send_req(REQ_SNAP, '0, '0, '0);
        send_req(REQ_ACK, '0, '0, '0);
        send_req(REQ_STATE, '0, 2'd3, '1);
        send_req(REQ_DELETE, '0, 2'd1, '0);
        send_req(REQ_STATE, '1, 2'd3, '1);
        send_req(REQ_DELETE, 'd1, 2'd3, '0);
        send_req(REQ_STATE, '1, 2'd2, '0);
        for (int k = 2; k <= 7; k++) begin
            send_req(REQ_STATE, PORT_KEY_W'(k), STATE_W'(k), '0);
        end
        send_req(REQ_STATE, 'd8, 2'd1, '0);
        send_req(REQ_SNAP, '0, '0, '0);
        send_req(REQ_ACK, 'd1, '0, pool_seq[1]);
        send_req(REQ_ACK, 'd2, '0, pool_seq[3]);
        send_req(REQ_ACK, 'd2, '0, pool_seq[2]);
        send_req(REQ_STATE, 'd5, 2'd1, '0);
        send_req(REQ_DELETE, 'd9, 2'd2, '0);
        send_req(REQ_SNAP, '0, '0, '0);
        send_req(REQ_ACK, 'd8, '0, pool_seq[8]);
        send_req(REQ_SNAP, '0, '0, '0);
        wait_drained();
        refresh_pool();

        // Random: enqueues from a small key pool, snapshots, and acknowledges that
        // mostly target the latest enqueue of a key.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 100) begin
                calm <= 1'b1;
            end
            if (n == 200) begin
                calm <= 1'b0;
            end
            if (n == 250) begin
                long_hold <= 1'b1;
            end
            if (n == 330 || n == 430) begin
                wait_drained();
                refresh_pool();
            end
            r = $urandom_range(0, 99);
            if (r < 35) begin
                send_req(REQ_STATE, pick_key(), STATE_W'($urandom), $urandom);
            end else if (r < 50) begin
                send_req(REQ_DELETE, pick_key(), STATE_W'($urandom), $urandom);
            end else if (r < 68) begin
                send_req(REQ_SNAP, $urandom, STATE_W'($urandom), $urandom);
            end else begin
                j = $urandom_range(0, POOL - 1);
                r = $urandom_range(0, 99);
                if (pool_seen[j] && r < 85) begin
                    key = pool_key[j];
                    seq = pool_seq[j];
                    // A few near misses on the sequence number.
                    if (r < 8) begin
                        seq = seq + 1'b1;
                    end
                end else begin
                    key = pick_key();
                    seq = $urandom;
                end
                send_req(REQ_ACK, key, STATE_W'($urandom), seq);
            end
            if (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
                rest_sender();
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
